[rtl/stream_variance_stats_top_assert.svh]
// assertion macros for the variance statistics block
`ifndef STREAM_VARIANCE_STATS_TOP_ASSERT_SVH
`define STREAM_VARIANCE_STATS_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define SVS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("svs assertion failed");
`define SVS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("svs assertion failed");
`else
`define SVS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SVS_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

[rtl/svs_pkg.sv]
// shared types and codes for the variance statistics block
`default_nettype none
package svs_pkg;

  typedef enum logic [2:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL,
    ALU_DIV,
    ALU_SQRT
  } alu_op_e;

  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } alu_stat_t;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_FEW = 2'd1,
    ST_OVF = 2'd2
  } status_e;

  localparam logic [2:0] STAT_VAR_N  = 3'd0;
  localparam logic [2:0] STAT_SD_N   = 3'd1;
  localparam logic [2:0] STAT_VAR_N1 = 3'd2;
  localparam logic [2:0] STAT_SD_N1  = 3'd3;
  localparam logic [2:0] STAT_SSQ    = 3'd4;

  localparam logic [1:0] REG_MEAN_MODE  = 2'd0;
  localparam logic [1:0] REG_FIXED_MEAN = 2'd1;
  localparam logic [1:0] REG_STATISTIC  = 2'd2;

  localparam int unsigned VALUE_W = 60;
  localparam int unsigned CFG_W   = 32;

endpackage
`default_nettype wire

[rtl/svs_accum.sv]
// running count, sum and sum of squares of one data set
`default_nettype none
module svs_accum import svs_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned MAX_SAMPLES = 4096,
  parameter int unsigned CNT_W       = 13,
  parameter int unsigned SUM_W       = 29,
  parameter int unsigned SQ_W        = 45
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    en_i,
  input  wire logic                    clear_i,
  input  wire logic [SAMPLE_BITS-1:0]  sample_i,
  output logic      [CNT_W-1:0]        count_o,
  output logic signed [SUM_W-1:0]      sum_o,
  output logic      [SQ_W-1:0]         sq_o,
  output logic                         ovf_o
);

  logic        [CNT_W-1:0]         count_q;
  logic signed [SUM_W-1:0]         sum_q;
  logic        [SQ_W-1:0]          sq_q;
  logic                            ovf_q;
  logic signed [SAMPLE_BITS-1:0]   smp;
  logic signed [2*SAMPLE_BITS-1:0] smp_sq;
  logic                            full;

  assign smp    = signed'(sample_i);
  assign smp_sq = smp * smp;
  assign full   = (count_q >= CNT_W'(MAX_SAMPLES));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      sum_q   <= '0;
      sq_q    <= '0;
      ovf_q   <= 1'b0;
    end else if (clear_i) begin
      count_q <= '0;
      sum_q   <= '0;
      sq_q    <= '0;
      ovf_q   <= 1'b0;
    end else if (en_i) begin
      if (full) begin
        ovf_q <= 1'b1;
      end else begin
        count_q <= count_q + CNT_W'(1);
        sum_q   <= sum_q + SUM_W'(smp);
        sq_q    <= sq_q + SQ_W'($unsigned(smp_sq));
      end
    end
  end

  assign count_o = count_q;
  assign sum_o   = sum_q;
  assign sq_o    = sq_q;
  assign ovf_o   = ovf_q;

endmodule
`default_nettype wire

[rtl/svs_alu.sv]
// shared add/subtract unit stepping multiply, divide and square root
`default_nettype none
module svs_alu import svs_pkg::*; #(
  parameter int unsigned W = 92
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire alu_cmd_t     cmd_i,
  input  wire logic [W-1:0] opa_i,
  input  wire logic [W-1:0] opb_i,
  output logic      [W-1:0] res_o,
  output alu_stat_t         stat_o
);

  localparam int unsigned CW = $clog2(W + 1);
  localparam int unsigned HW = W / 2;

  alu_op_e       op_q;
  logic          busy_q, done_q;
  logic [CW-1:0] cnt_q;
  logic [W-1:0]  x_q, y_q, m_q, r_q;
  logic [W:0]    add_a, add_b, add_s;
  logic          add_sub, borrow, fin;

  // the one wide adder everything goes through
  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_sub = 1'b0;
    case (op_q)
      ALU_ADD: begin
        add_a = {1'b0, x_q};
        add_b = {1'b0, y_q};
      end
      ALU_SUB: begin
        add_a   = {1'b0, x_q};
        add_b   = {1'b0, y_q};
        add_sub = 1'b1;
      end
      ALU_MUL: begin
        add_a = {1'b0, x_q};
        add_b = {1'b0, y_q};
      end
      ALU_DIV: begin
        add_a   = {1'b0, r_q[W-2:0], x_q[W-1]};
        add_b   = {1'b0, y_q};
        add_sub = 1'b1;
      end
      ALU_SQRT: begin
        add_a   = {1'b0, r_q[W-3:0], x_q[W-1:W-2]};
        add_b   = {1'b0, y_q[W-3:0], 2'b01};
        add_sub = 1'b1;
      end
      default: begin
        add_a = '0;
      end
    endcase
    add_s  = add_sub ? (add_a - add_b) : (add_a + add_b);
    borrow = add_s[W];
  end

  always_comb begin
    case (op_q)
      ALU_MUL:           fin = (m_q == '0);
      ALU_DIV, ALU_SQRT: fin = (cnt_q == CW'(1));
      default:           fin = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q   <= ALU_ADD;
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (cmd_i.start) begin
      op_q   <= cmd_i.op;
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= (cmd_i.op == ALU_SQRT) ? CW'(HW) : CW'(W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CW'(1);
      if (fin) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      case (cmd_i.op)
        ALU_MUL: begin
          x_q <= '0;
          y_q <= opa_i;
          m_q <= opb_i;
        end
        ALU_DIV: begin
          x_q <= opa_i;
          y_q <= opb_i;
          r_q <= '0;
        end
        ALU_SQRT: begin
          x_q <= opa_i;
          y_q <= '0;
          r_q <= '0;
        end
        default: begin
          x_q <= opa_i;
          y_q <= opb_i;
        end
      endcase
    end else if (busy_q) begin
      case (op_q)
        ALU_ADD, ALU_SUB: x_q <= add_s[W-1:0];
        ALU_MUL: begin
          if (!fin) begin
            if (m_q[0]) x_q <= add_s[W-1:0];
            y_q <= {y_q[W-2:0], 1'b0};
            m_q <= {1'b0, m_q[W-1:1]};
          end
        end
        ALU_DIV: begin
          r_q <= borrow ? add_a[W-1:0] : add_s[W-1:0];
          x_q <= {x_q[W-2:0], ~borrow};
        end
        ALU_SQRT: begin
          r_q <= borrow ? add_a[W-1:0] : add_s[W-1:0];
          y_q <= {y_q[W-2:0], ~borrow};
          x_q <= {x_q[W-3:0], 2'b00};
        end
        default: x_q <= x_q;
      endcase
    end
  end

  assign res_o  = (op_q == ALU_SQRT) ? y_q : x_q;
  assign stat_o = '{busy: busy_q, done: done_q};

endmodule
`default_nettype wire

[rtl/stream_variance_stats_top.sv]
// variance and standard deviation of a sample stream, top level
//
//  channel | dir | signals                                 | handshake
//  in      | in  | sample_i, last_i                        | in_valid_i / in_ready_o
//  out     | out | value_o, status_o, sample_count_o       | out_valid_o / out_ready_i
//  cfg     | in  | cfg_idx_i, cfg_wdata_i                  | cfg_we_i, always taken
//
// samples accumulate at one per cycle while in_ready_o is high; in_ready_o stays high while accumulating
// after the last sample the shared adder runs the multiplies, adds, subtracts and divides of the chosen
// mean mode, then the root for a standard deviation
// a flagged set skips the arithmetic and goes from the check straight to the done state
// in_ready_o is low from the last sample until its result has gone into the output register
// reset clears counts and the output register and sets the configuration to its defaults; no clearing pass
`default_nettype none
module stream_variance_stats_top import svs_pkg::*; #(
  parameter int unsigned MAX_SAMPLES = 4096,
  parameter int unsigned SAMPLE_BITS = 16,
  localparam int unsigned CNT_W = $clog2(MAX_SAMPLES + 1)
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic [SAMPLE_BITS-1:0] sample_i,
  input  wire logic                   last_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic [VALUE_W-1:0]          value_o,
  output logic [1:0]                  status_o,
  output logic [CNT_W-1:0]            sample_count_o,
  input  wire logic                   cfg_we_i,
  input  wire logic [1:0]             cfg_idx_i,
  input  wire logic [CFG_W-1:0]       cfg_wdata_i
);

  `include "stream_variance_stats_top_assert.svh"

  localparam int unsigned SUM_W = SAMPLE_BITS + CNT_W;
  localparam int unsigned SQ_W  = 2 * SAMPLE_BITS + CNT_W;
  localparam int unsigned WA    = SQ_W + CNT_W + 32;
  localparam int unsigned WB    = CNT_W + 64;
  localparam int unsigned WC    = SUM_W + 50;
  localparam int unsigned WM    = (WA > WB) ? WA : WB;
  localparam int unsigned WN    = ((WM > WC) ? WM : WC) + 2;
  localparam int unsigned DP_W  = WN + (WN % 2);

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK,
    S_F_MSQ, S_F_NMSQ, S_F_BASE, S_F_CROSS, S_F_MIX,
    S_C_NS2, S_C_S1SQ, S_C_DIFF, S_C_MEAN,
    S_DIVK, S_ROOT, S_DONE
  } state_e;

  // configuration
  logic              mean_mode_q;
  logic [CFG_W-1:0]  fixed_mean_q;
  logic [2:0]        statistic_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mean_mode_q  <= 1'b0;
      fixed_mean_q <= '0;
      statistic_q  <= STAT_VAR_N1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MEAN_MODE:  mean_mode_q  <= cfg_wdata_i[0];
        REG_FIXED_MEAN: fixed_mean_q <= cfg_wdata_i;
        REG_STATISTIC:  statistic_q  <= cfg_wdata_i[2:0];
        default:        mean_mode_q  <= mean_mode_q;
      endcase
    end
  end

  state_e             state_q, state_d;
  logic               pend_q;
  logic               out_valid_q;
  logic [VALUE_W-1:0] value_q;
  logic [1:0]         status_q;
  logic [CNT_W-1:0]   count_out_q;
  status_e            flag_q, flag_d;
  logic [DP_W-1:0]    acc_q, tmp_q;

  logic               acc_en, acc_clear;
  logic [CNT_W-1:0]   cnt;
  logic signed [SUM_W-1:0] s1;
  logic [SQ_W-1:0]    s2;
  logic               ovf;

  svs_accum #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .MAX_SAMPLES (MAX_SAMPLES),
    .CNT_W       (CNT_W),
    .SUM_W       (SUM_W),
    .SQ_W        (SQ_W)
  ) u_accum (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (acc_en),
    .clear_i  (acc_clear),
    .sample_i (sample_i),
    .count_o  (cnt),
    .sum_o    (s1),
    .sq_o     (s2),
    .ovf_o    (ovf)
  );

  alu_cmd_t        cmd;
  alu_stat_t       alu_st;
  logic [DP_W-1:0] opa, opb, alu_res;

  svs_alu #(.W(DP_W)) u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .opa_i  (opa),
    .opb_i  (opb),
    .res_o  (alu_res),
    .stat_o (alu_st)
  );

  logic [CNT_W-1:0] n;
  logic [SUM_W-1:0] abs_s1;
  logic [CFG_W-1:0] abs_m;
  logic [DP_W-1:0]  n_ext, k_ext;
  logic             is_sd, few, to_tmp, out_free;
  logic [VALUE_W-1:0] fin_val;
  logic [DP_W-1:0]  var_sh;

  assign n      = (cnt == '0) ? CNT_W'(1) : cnt;
  assign abs_s1 = s1[SUM_W-1] ? SUM_W'(-s1) : SUM_W'(s1);
  assign abs_m  = fixed_mean_q[CFG_W-1] ? (~fixed_mean_q + CFG_W'(1)) : fixed_mean_q;
  assign n_ext  = DP_W'(n);
  assign is_sd  = (statistic_q == STAT_SD_N) || (statistic_q == STAT_SD_N1);
  assign few    = ((statistic_q == STAT_VAR_N1) || (statistic_q == STAT_SD_N1)) &&
                  (cnt < CNT_W'(2));

  always_comb begin
    if (statistic_q >= STAT_SSQ) begin
      k_ext = DP_W'(32'd65536);
    end else if (statistic_q <= STAT_SD_N) begin
      k_ext = n_ext;
    end else begin
      k_ext = n_ext - DP_W'(1);
    end
  end

  // one step of the program per state
  always_comb begin
    cmd.op = ALU_MUL;
    opa    = '0;
    opb    = '0;
    to_tmp = 1'b0;
    case (state_q)
      S_F_MSQ: begin
        opa = DP_W'(abs_m);
        opb = DP_W'(abs_m);
        to_tmp = 1'b1;
      end
      S_F_NMSQ: begin
        opa = tmp_q;
        opb = n_ext;
        to_tmp = 1'b1;
      end
      S_F_BASE: begin
        cmd.op = ALU_ADD;
        opa = DP_W'(s2) << 32;
        opb = tmp_q;
      end
      S_F_CROSS: begin
        opa = DP_W'(abs_s1);
        opb = DP_W'(abs_m);
        to_tmp = 1'b1;
      end
      S_F_MIX: begin
        // cross term adds when the mean and the sum have opposite signs
        cmd.op = (fixed_mean_q[CFG_W-1] != s1[SUM_W-1]) ? ALU_ADD : ALU_SUB;
        opa = acc_q;
        opb = tmp_q << 17;
      end
      S_C_NS2: begin
        opa = DP_W'(s2);
        opb = n_ext;
      end
      S_C_S1SQ: begin
        opa = DP_W'(abs_s1);
        opb = DP_W'(abs_s1);
        to_tmp = 1'b1;
      end
      S_C_DIFF: begin
        cmd.op = ALU_SUB;
        opa = acc_q;
        opb = tmp_q;
      end
      S_C_MEAN: begin
        cmd.op = ALU_DIV;
        opa = acc_q << 32;
        opb = n_ext;
      end
      S_DIVK: begin
        cmd.op = ALU_DIV;
        opa = acc_q;
        opb = k_ext;
      end
      S_ROOT: begin
        cmd.op = ALU_SQRT;
        opa = acc_q;
      end
      default: begin
        opa = '0;
      end
    endcase
    case (state_q)
      S_IDLE, S_CHECK, S_DONE: cmd.start = 1'b0;
      default:                 cmd.start = !pend_q;
    endcase
  end

  always_comb begin
    state_d = state_q;
    flag_d  = flag_q;
    case (state_q)
      S_IDLE: if (acc_en && last_i) state_d = S_CHECK;
      S_CHECK: begin
        if (ovf) begin
          flag_d  = ST_OVF;
          state_d = S_DONE;
        end else if (few) begin
          flag_d  = ST_FEW;
          state_d = S_DONE;
        end else begin
          flag_d  = ST_OK;
          state_d = mean_mode_q ? S_C_NS2 : S_F_MSQ;
        end
      end
      S_F_MSQ:   if (alu_st.done) state_d = S_F_NMSQ;
      S_F_NMSQ:  if (alu_st.done) state_d = S_F_BASE;
      S_F_BASE:  if (alu_st.done) state_d = S_F_CROSS;
      S_F_CROSS: if (alu_st.done) state_d = S_F_MIX;
      S_F_MIX:   if (alu_st.done) state_d = S_DIVK;
      S_C_NS2:   if (alu_st.done) state_d = S_C_S1SQ;
      S_C_S1SQ:  if (alu_st.done) state_d = S_C_DIFF;
      S_C_DIFF:  if (alu_st.done) state_d = S_C_MEAN;
      S_C_MEAN:  if (alu_st.done) state_d = S_DIVK;
      S_DIVK:    if (alu_st.done) state_d = is_sd ? S_ROOT : S_DONE;
      S_ROOT:    if (alu_st.done) state_d = S_DONE;
      S_DONE:    if (out_free) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);
  assign acc_en     = in_valid_i && in_ready_o;
  assign acc_clear  = (state_q == S_DONE) && out_free;

  assign var_sh = (is_sd || statistic_q >= STAT_SSQ) ? acc_q : (acc_q >> 16);

  always_comb begin
    if (flag_q != ST_OK) begin
      fin_val = '0;
    end else if (var_sh[DP_W-1:VALUE_W] != '0) begin
      fin_val = '1;
    end else begin
      fin_val = var_sh[VALUE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pend_q      <= 1'b0;
      flag_q      <= ST_OK;
      out_valid_q <= 1'b0;
      value_q     <= '0;
      status_q    <= '0;
      count_out_q <= '0;
    end else begin
      state_q <= state_d;
      flag_q  <= flag_d;
      if (cmd.start) begin
        pend_q <= 1'b1;
      end else if (alu_st.done) begin
        pend_q <= 1'b0;
      end
      if (acc_clear) begin
        out_valid_q <= 1'b1;
        value_q     <= fin_val;
        status_q    <= flag_q;
        count_out_q <= cnt;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (alu_st.done && pend_q) begin
      if (to_tmp) begin
        tmp_q <= alu_res;
      end else begin
        acc_q <= alu_res;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign value_o        = value_q;
  assign status_o       = status_q;
  assign sample_count_o = count_out_q;

  `SVS_ASSERT_IMP(a_idle_alu_quiet, clk_i, rst_ni, state_q == S_IDLE, !alu_st.busy)
  `SVS_ASSERT_IMP(a_flag_zero_value, clk_i, rst_ni, out_valid_q && status_q != ST_OK, value_q == '0)
  `SVS_ASSERT_IMP(a_count_bound, clk_i, rst_ni, out_valid_q, count_out_q <= CNT_W'(MAX_SAMPLES))
  `SVS_ASSERT_NXT(a_last_blocks, clk_i, rst_ni, acc_en && last_i, !in_ready_o)

endmodule
`default_nettype wire
